@@ hdl/keyed_task_coalescing_batcher_macros.svh @@
// Assertion helpers for the coalescing batcher.
// Both expect i_clk and i_rst_n in the scope where they are used; checks are
// off while reset is held.
`ifndef KEYED_TASK_COALESCING_BATCHER_MACROS_SVH
`define KEYED_TASK_COALESCING_BATCHER_MACROS_SVH

// Property checked at every clock edge.
`define KTCB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent at one edge, consequent at the next.
`define KTCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ktcb_pkg.sv @@
package ktcb_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PAGE_W      = 32;
    localparam int DB_W        = 8;
    localparam int COUNT_W     = 8;
    localparam int PEND_W      = 11;
    localparam int SLOT_IDX_W  = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
    localparam logic [PEND_W-1:0]  PEND_MAX  = 11'h7FF;
    localparam logic [COUNT_W-1:0] PBL_RESET = 8'd16;
    localparam logic [PEND_W-1:0]  TPL_RESET = 11'd64;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_PER_BATCH_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PENDING_LIMIT = 2'd1;

    // post kinds
    localparam logic KIND_BATCH  = 1'b0;
    localparam logic KIND_DIRECT = 1'b1;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        logic                    post_kind;
        logic [SLOT_IDX_W-1:0]   slot_index;
        logic [PAGE_W-1:0]       post_page;
        logic [DB_W-1:0]         post_database;
        logic [COUNT_W-1:0]      post_count;
        logic                    last_of_run;
    } t_post;

    typedef struct packed {
        logic  push;
        t_post data;
    } t_q_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // reported slot number keeps the low bits only
    function automatic logic [SLOT_IDX_W-1:0] slot_to_index(input t_slot s);
        logic [31:0] w;
        w = 32'(s);
        return w[SLOT_IDX_W-1:0];
    endfunction

endpackage

@@ hdl/ktcb_ifs.sv @@
interface ktcb_req_if import ktcb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_number;
    logic [DB_W-1:0]   database_id;

    modport source (output valid, output page_number, output database_id, input ready);
    modport sink   (input valid, input page_number, input database_id, output ready);
endinterface

interface ktcb_post_if import ktcb_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic                  post_kind;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [PAGE_W-1:0]     post_page;
    logic [DB_W-1:0]       post_database;
    logic [COUNT_W-1:0]    post_count;
    logic                  last_of_run;

    modport source (
        output valid, output post_kind, output slot_index, output post_page,
        output post_database, output post_count, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input post_kind, input slot_index, input post_page,
        input post_database, input post_count, input last_of_run,
        output ready
    );
endinterface

@@ hdl/ktcb_front.sv @@
module ktcb_front import ktcb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg_wr    i_cfg,
    ktcb_req_if.sink   i_req,
    input  logic       i_q_full,
    output t_q_push    o_push
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_FLUSH  = 2'd2;
    localparam logic [1:0] S_DIRECT = 2'd3;

    logic [1:0] r_state, n_state;

    logic [COUNT_W-1:0] r_pbl, n_pbl;
    logic [PEND_W-1:0]  r_tpl, n_tpl;

    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    logic [PAGE_W-1:0]    r_page  [NUM_SLOTS];
    logic [PAGE_W-1:0]    n_page  [NUM_SLOTS];
    logic [DB_W-1:0]      r_db    [NUM_SLOTS];
    logic [DB_W-1:0]      n_db    [NUM_SLOTS];
    logic [COUNT_W-1:0]   r_count [NUM_SLOTS];
    logic [COUNT_W-1:0]   n_count [NUM_SLOTS];
    logic [PEND_W-1:0]    r_pend, n_pend;

    // request held between accept and execute
    logic [PAGE_W-1:0] r_key_page, n_key_page;
    logic [DB_W-1:0]   r_key_db, n_key_db;
    logic              r_hit, n_hit;
    logic              r_has_free, n_has_free;
    t_slot             r_match, n_match;
    t_slot             r_free, n_free;

    // flush walk
    logic [NUM_SLOTS-1:0] r_mask, n_mask;
    logic                 r_direct, n_direct;

    logic  hit_c, free_found_c;
    t_slot match_c, free_c;
    t_slot flush_idx;
    t_slot sel_idx;

    logic [COUNT_W-1:0]   rd_count;
    logic [PAGE_W-1:0]    rd_page;
    logic [DB_W-1:0]      rd_db;
    logic [COUNT_W-1:0]   cnt_inc;
    logic [PEND_W-1:0]    pend_inc;
    logic [PEND_W-1:0]    pend_after_post;
    logic [PEND_W-1:0]    pend_sub;
    logic                 post_now;
    logic [NUM_SLOTS-1:0] match_bit, free_bit, flush_bit;
    logic [NUM_SLOTS-1:0] rest_mask, mask_left;
    logic                 flush_more;

    assign i_req.ready = (r_state == S_IDLE);

    // parallel key match and lowest free slot
    always_comb begin
        hit_c        = 1'b0;
        match_c      = '0;
        free_found_c = 1'b0;
        free_c       = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (r_valid[s]) begin
                if (!hit_c && r_page[s] == i_req.page_number
                        && r_db[s] == i_req.database_id) begin
                    hit_c   = 1'b1;
                    match_c = SLOT_W'(s);
                end
            end else if (!free_found_c) begin
                free_found_c = 1'b1;
                free_c       = SLOT_W'(s);
            end
        end
    end

    always_comb begin
        flush_idx = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (r_mask[s]) begin
                flush_idx = SLOT_W'(s);
            end
        end
    end

    // single slot read port
    assign sel_idx  = (r_state == S_FLUSH) ? flush_idx : r_match;
    assign rd_count = r_count[sel_idx];
    assign rd_page  = r_page[sel_idx];
    assign rd_db    = r_db[sel_idx];

    assign cnt_inc  = (rd_count == COUNT_MAX) ? COUNT_MAX : rd_count + COUNT_W'(1);
    assign pend_inc = (r_pend == PEND_MAX) ? PEND_MAX : r_pend + PEND_W'(1);
    assign post_now = (cnt_inc >= r_pbl);
    assign pend_after_post = (pend_inc >= PEND_W'(cnt_inc))
                           ? pend_inc - PEND_W'(cnt_inc) : '0;
    assign pend_sub = (r_pend >= PEND_W'(rd_count))
                    ? r_pend - PEND_W'(rd_count) : '0;

    assign match_bit  = NUM_SLOTS'(1) << r_match;
    assign free_bit   = NUM_SLOTS'(1) << r_free;
    assign flush_bit  = NUM_SLOTS'(1) << flush_idx;
    assign rest_mask  = r_valid & ~match_bit;
    assign mask_left  = r_mask & ~flush_bit;
    assign flush_more = (pend_after_post >= r_tpl) && (rest_mask != '0);

    always_comb begin
        n_state    = r_state;
        n_pbl      = r_pbl;
        n_tpl      = r_tpl;
        n_valid    = r_valid;
        n_page     = r_page;
        n_db       = r_db;
        n_count    = r_count;
        n_pend     = r_pend;
        n_key_page = r_key_page;
        n_key_db   = r_key_db;
        n_hit      = r_hit;
        n_has_free = r_has_free;
        n_match    = r_match;
        n_free     = r_free;
        n_mask     = r_mask;
        n_direct   = r_direct;
        o_push     = '0;

        if (i_cfg.we) begin
            unique case (i_cfg.idx)
                REG_PER_BATCH_LIMIT:     n_pbl = i_cfg.data[COUNT_W-1:0];
                REG_TOTAL_PENDING_LIMIT: n_tpl = i_cfg.data[PEND_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_key_page = i_req.page_number;
                    n_key_db   = i_req.database_id;
                    n_hit      = hit_c;
                    n_match    = match_c;
                    n_has_free = free_found_c;
                    n_free     = free_c;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_hit) begin
                    if (post_now) begin
                        if (!i_q_full) begin
                            o_push.push               = 1'b1;
                            o_push.data.post_kind     = KIND_BATCH;
                            o_push.data.slot_index    = slot_to_index(r_match);
                            o_push.data.post_page     = r_key_page;
                            o_push.data.post_database = r_key_db;
                            o_push.data.post_count    = cnt_inc;
                            o_push.data.last_of_run   = !flush_more;
                            n_valid[r_match] = 1'b0;
                            n_count[r_match] = '0;
                            n_pend           = pend_after_post;
                            n_mask           = rest_mask;
                            n_direct         = 1'b0;
                            n_state          = flush_more ? S_FLUSH : S_IDLE;
                        end
                    end else begin
                        n_count[r_match] = cnt_inc;
                        n_pend           = pend_inc;
                        n_mask           = r_valid;
                        n_direct         = 1'b0;
                        n_state          = (pend_inc >= r_tpl) ? S_FLUSH : S_IDLE;
                    end
                end else if (r_has_free) begin
                    n_valid[r_free] = 1'b1;
                    n_page[r_free]  = r_key_page;
                    n_db[r_free]    = r_key_db;
                    n_count[r_free] = COUNT_W'(1);
                    n_pend          = pend_inc;
                    n_mask          = r_valid | free_bit;
                    n_direct        = 1'b0;
                    n_state         = (pend_inc >= r_tpl) ? S_FLUSH : S_IDLE;
                end else begin
                    // table full: flush every slot, then post the request alone
                    n_mask   = r_valid;
                    n_direct = 1'b1;
                    n_state  = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_q_full) begin
                    o_push.push               = 1'b1;
                    o_push.data.post_kind     = KIND_BATCH;
                    o_push.data.slot_index    = slot_to_index(flush_idx);
                    o_push.data.post_page     = rd_page;
                    o_push.data.post_database = rd_db;
                    o_push.data.post_count    = rd_count;
                    o_push.data.last_of_run   = (mask_left == '0) && !r_direct;
                    n_valid[flush_idx] = 1'b0;
                    n_count[flush_idx] = '0;
                    n_pend             = pend_sub;
                    n_mask             = mask_left;
                    if (mask_left == '0) begin
                        n_state = r_direct ? S_DIRECT : S_IDLE;
                    end
                end
            end
            S_DIRECT: begin
                if (!i_q_full) begin
                    o_push.push               = 1'b1;
                    o_push.data.post_kind     = KIND_DIRECT;
                    o_push.data.slot_index    = '0;
                    o_push.data.post_page     = r_key_page;
                    o_push.data.post_database = r_key_db;
                    o_push.data.post_count    = COUNT_W'(1);
                    o_push.data.last_of_run   = 1'b1;
                    n_direct = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pbl    <= PBL_RESET;
            r_tpl    <= TPL_RESET;
            r_valid  <= '0;
            r_pend   <= '0;
            r_mask   <= '0;
            r_direct <= 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_count[s] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_pbl    <= n_pbl;
            r_tpl    <= n_tpl;
            r_valid  <= n_valid;
            r_pend   <= n_pend;
            r_mask   <= n_mask;
            r_direct <= n_direct;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page     <= n_page;
        r_db       <= n_db;
        r_key_page <= n_key_page;
        r_key_db   <= n_key_db;
        r_hit      <= n_hit;
        r_has_free <= n_has_free;
        r_match    <= n_match;
        r_free     <= n_free;
    end

endmodule

@@ hdl/ktcb_queue.sv @@
module ktcb_queue import ktcb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_push   i_push,
    input  logic      i_pop,
    output t_q_status o_status,
    output t_post     o_data
);

    t_post                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_cnt, n_cnt;
    logic                   do_push, do_pop;

    assign o_status.full  = (r_cnt == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_data         = r_mem[r_rd_ptr];

    assign do_push = i_push.push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QUEUE_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + QUEUE_PTR_W'(1) : r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + (QUEUE_PTR_W + 1)'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - (QUEUE_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

endmodule

@@ hdl/ktcb_back.sv @@
module ktcb_back import ktcb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_status   i_q_status,
    input  t_post       i_q_data,
    output logic        o_pop,
    ktcb_post_if.source o_post
);

    logic  r_valid, n_valid;
    t_post r_data;
    logic  load;

    // output register refills when empty or when the sink takes it
    assign load    = !r_valid || o_post.ready;
    assign o_pop   = load && !i_q_status.empty;
    assign n_valid = load ? !i_q_status.empty : r_valid;

    assign o_post.valid         = r_valid;
    assign o_post.post_kind     = r_data.post_kind;
    assign o_post.slot_index    = r_data.slot_index;
    assign o_post.post_page     = r_data.post_page;
    assign o_post.post_database = r_data.post_database;
    assign o_post.post_count    = r_data.post_count;
    assign o_post.last_of_run   = r_data.last_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_q_data;
        end
    end

endmodule

@@ hdl/keyed_task_coalescing_batcher.sv @@
// Keyed task coalescing batcher.
// i_req carries task requests keyed by (page_number, database_id); o_post
// returns one transaction per posted batch or direct task, with last_of_run
// set on the final transaction caused by a request. A request that posts
// nothing produces no transaction. Both channels use valid/ready.
// Config: i_cfg_we with i_cfg_idx selects per_batch_limit (0) or
// total_pending_limit (1); write only while the block is idle.
// Sequence: a request that posts nothing is accepted, then updates its slot.
// A batch posted by the request's own hit leaves in the update cycle; every
// other posted batch or direct task leaves from its own flush or direct step,
// set by the single slot read port that walks the flush mask one slot per
// cycle while the queue has room, so a request that finds the table full
// flushes every slot and then posts itself. The first result reaches o_post
// through the queue and then the output register.
// Reset (synchronous, active low) empties all slots, zeroes the pending
// total and loads the limits with 16 and 64; no clearing pass is needed.
// When the receiver stalls, results wait in a 4-entry queue plus the output
// register; once the queue fills, a front step that must post holds its state
// until room opens, and i_req.ready is low whenever the front is not idle.
module keyed_task_coalescing_batcher import ktcb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ktcb_req_if.sink              i_req,
    ktcb_post_if.source           o_post
);

    t_cfg_wr   cfg;
    t_q_push   q_push;
    t_q_status q_status;
    t_post     q_data;
    logic      q_pop;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // front: key match, slot table, flush sequencing
    ktcb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_req    (i_req),
        .i_q_full (q_status.full),
        .o_push   (q_push)
    );

    // decouples the sequencer from output back-pressure
    ktcb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_pop    (q_pop),
        .o_status (q_status),
        .o_data   (q_data)
    );

    // back: registered output channel
    ktcb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_data   (q_data),
        .o_pop      (q_pop),
        .o_post     (o_post)
    );

endmodule

@@ hdl/ktcb_checker.sv @@
`include "keyed_task_coalescing_batcher_macros.svh"

module ktcb_checker import ktcb_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic                  i_post_kind,
    input logic [SLOT_IDX_W-1:0] i_slot_index,
    input logic [COUNT_W-1:0]    i_post_count,
    input logic                  i_last_of_run
);

    logic out_direct;
    logic direct_shape_ok;
    logic in_fire;
    logic out_stall;

    assign out_direct      = i_out_valid && (i_post_kind == KIND_DIRECT);
    assign direct_shape_ok = (i_slot_index == '0) && (i_post_count == COUNT_W'(1))
                           && i_last_of_run;
    assign in_fire         = i_in_valid && i_in_ready;
    assign out_stall       = i_out_valid && !i_out_ready;

    `KTCB_ASSERT(a_direct_shape, out_direct |-> direct_shape_ok, "direct post malformed")
    `KTCB_ASSERT(a_count_nonzero, i_out_valid |-> (i_post_count != '0), "zero count post")
    `KTCB_ASSERT_NEXT(a_no_back_to_back, in_fire, !i_in_ready, "request taken during execute")
    `KTCB_ASSERT_NEXT(a_out_hold, out_stall,
        i_out_valid && $stable(i_post_count) && $stable(i_last_of_run),
        "stalled result changed")

endmodule

bind keyed_task_coalescing_batcher ktcb_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_post.valid),
    .i_out_ready   (o_post.ready),
    .i_post_kind   (o_post.post_kind),
    .i_slot_index  (o_post.slot_index),
    .i_post_count  (o_post.post_count),
    .i_last_of_run (o_post.last_of_run)
);
